@@ design/bgfp_pkg.sv @@
// Shared types and constants for the binary GNSS frame parser.
// Used by bgfp_core and binary_gnss_frame_parser_unit; depends on nothing else.
`default_nettype none

package bgfp_pkg;

    // Frame sync pair and the limit after reset.
    localparam logic [7:0]  SYNC_FIRST     = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND    = 8'h62;
    localparam logic [15:0] LIMIT_AT_RESET = 16'd200;

    // Known message class and id codes.
    localparam logic [7:0] CLASS_NAV = 8'h01;
    localparam logic [7:0] IDENT_PVT = 8'h07;
    localparam logic [7:0] CLASS_ACK = 8'h05;
    localparam logic [7:0] IDENT_ACK = 8'h01;
    localparam logic [7:0] IDENT_NAK = 8'h00;

    // Request types carried with each input transfer.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_WAIT = 1'b1;

    // Error codes reported with each result.
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SYNC2    = 3'd1,
        ERR_TOO_LONG = 3'd2,
        ERR_CK_A     = 3'd3,
        ERR_CK_B     = 3'd4
    } t_err;

    // Acknowledge tracking; the codes are those seen on the ack_state output.
    typedef enum logic [1:0] {
        ACK_IDLE    = 2'd0,
        ACK_WAITING = 2'd1,
        ACK_GOT_ACK = 2'd2,
        ACK_GOT_NAK = 2'd3
    } t_ack;

    // Parser phase, one-hot.
    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b0_0000_0001,
        PH_SYNC2   = 9'b0_0000_0010,
        PH_CLASS   = 9'b0_0000_0100,
        PH_IDENT   = 9'b0_0000_1000,
        PH_LEN_LO  = 9'b0_0001_0000,
        PH_LEN_HI  = 9'b0_0010_0000,
        PH_PAYLOAD = 9'b0_0100_0000,
        PH_CK_A    = 9'b0_1000_0000,
        PH_CK_B    = 9'b1_0000_0000
    } t_phase;

    // One result item as it leaves the parser.
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  msg_class;
        logic [7:0]  msg_ident;
        logic        frame_end;
        logic        frame_known;
        t_err        error_code;
        t_ack        ack_state;
    } t_result;

endpackage

`default_nettype wire

@@ design/bgfp_core.sv @@
// Frame parser state and per-byte update logic.
// Depends on bgfp_pkg; the result is combinational and is registered by the top level.
`default_nettype none

module bgfp_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_req_type,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic [15:0]       i_payload_limit,
    output bgfp_pkg::t_result      o_result
);
    import bgfp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_ident, n_ident;
    logic [15:0] r_length, n_length;
    logic [15:0] r_taken, n_taken;
    t_ack        r_ack, n_ack;

    logic [7:0]  w_sum_a_in;
    logic [7:0]  w_sum_b_in;
    logic [16:0] w_taken_inc;
    logic [15:0] w_length_full;
    logic        w_restart;
    t_result     w_res;

    // Running Fletcher sums with the current byte folded in.
    assign w_sum_a_in    = r_sum_a + i_data_byte;
    assign w_sum_b_in    = r_sum_b + w_sum_a_in;
    assign w_taken_inc   = {1'b0, r_taken} + 17'd1;
    assign w_length_full = {i_data_byte, r_length[7:0]};

    // Next state and result for the byte at hand.
    always_comb begin
        n_phase   = r_phase;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_class   = r_class;
        n_ident   = r_ident;
        n_length  = r_length;
        n_taken   = r_taken;
        n_ack     = r_ack;
        w_restart = 1'b0;
        w_res     = '0;
        w_res.error_code = ERR_NONE;

        if (i_req_type == REQ_WAIT) begin
            w_restart = 1'b1;
            n_ack     = ACK_WAITING;
        end else begin
            unique case (r_phase)
                PH_SYNC1: begin
                    if (i_data_byte == SYNC_FIRST) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    if (i_data_byte == SYNC_SECOND) begin
                        n_phase = PH_CLASS;
                    end else begin
                        w_restart        = 1'b1;
                        w_res.error_code = ERR_SYNC2;
                    end
                end
                PH_CLASS: begin
                    n_sum_a = w_sum_a_in;
                    n_sum_b = w_sum_b_in;
                    n_class = i_data_byte;
                    n_phase = PH_IDENT;
                end
                PH_IDENT: begin
                    n_sum_a = w_sum_a_in;
                    n_sum_b = w_sum_b_in;
                    n_ident = i_data_byte;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_sum_a  = w_sum_a_in;
                    n_sum_b  = w_sum_b_in;
                    n_length = {8'd0, i_data_byte};
                    n_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_sum_a  = w_sum_a_in;
                    n_sum_b  = w_sum_b_in;
                    n_length = w_length_full;
                    // A zero-length frame goes straight to the checksum bytes.
                    n_phase  = (w_length_full != 16'd0) ? PH_PAYLOAD : PH_CK_A;
                end
                PH_PAYLOAD: begin
                    n_sum_a = w_sum_a_in;
                    n_sum_b = w_sum_b_in;
                    if (w_taken_inc > {1'b0, i_payload_limit}) begin
                        w_restart        = 1'b1;
                        w_res.error_code = ERR_TOO_LONG;
                    end else begin
                        w_res.payload_valid = 1'b1;
                        w_res.payload_byte  = i_data_byte;
                        w_res.payload_index = r_taken;
                        n_taken = w_taken_inc[15:0];
                        if (w_taken_inc[15:0] >= r_length) begin
                            n_phase = PH_CK_A;
                        end
                    end
                end
                PH_CK_A: begin
                    if (i_data_byte != r_sum_a) begin
                        w_restart        = 1'b1;
                        w_res.error_code = ERR_CK_A;
                    end else begin
                        n_phase = PH_CK_B;
                    end
                end
                PH_CK_B: begin
                    w_restart = 1'b1;
                    if (i_data_byte != r_sum_b) begin
                        w_res.error_code = ERR_CK_B;
                    end else begin
                        w_res.frame_end = 1'b1;
                        if (r_class == CLASS_NAV && r_ident == IDENT_PVT) begin
                            w_res.frame_known = 1'b1;
                        end else if (r_class == CLASS_ACK && r_ident == IDENT_ACK) begin
                            w_res.frame_known = 1'b1;
                            if (r_ack == ACK_WAITING) begin
                                n_ack = ACK_GOT_ACK;
                            end
                        end else if (r_class == CLASS_ACK && r_ident == IDENT_NAK) begin
                            w_res.frame_known = 1'b1;
                            if (r_ack == ACK_WAITING) begin
                                n_ack = ACK_GOT_NAK;
                            end
                        end
                    end
                end
                default: begin
                    w_restart = 1'b1;
                end
            endcase
        end

        // Decoder restart; class, ident and acknowledge state are kept.
        if (w_restart) begin
            n_phase  = PH_SYNC1;
            n_sum_a  = 8'd0;
            n_sum_b  = 8'd0;
            n_length = 16'd0;
            n_taken  = 16'd0;
        end

        w_res.msg_class = n_class;
        w_res.msg_ident = n_ident;
        w_res.ack_state = n_ack;
    end

    assign o_result = w_res;

    // Parser state advances once per byte taken from the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC1;
            r_sum_a  <= 8'd0;
            r_sum_b  <= 8'd0;
            r_class  <= 8'd0;
            r_ident  <= 8'd0;
            r_length <= 16'd0;
            r_taken  <= 16'd0;
            r_ack    <= ACK_IDLE;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
            r_class  <= n_class;
            r_ident  <= n_ident;
            r_length <= n_length;
            r_taken  <= n_taken;
            r_ack    <= n_ack;
        end
    end

endmodule

`default_nettype wire

@@ design/binary_gnss_frame_parser_unit.sv @@
// Top level of the binary GNSS frame parser: input register, parser core, result register.
// Depends on bgfp_pkg and bgfp_core.
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+-------------------------------------
//  in       | input     | i_in_valid / o_in_ready  | i_req_type, i_data_byte
//  out      | output    | o_out_valid / i_out_ready| o_payload_*, o_msg_*, o_frame_*, ...
//  cfg      | input     | i_cfg_valid / o_cfg_ready| i_cfg_payload_limit
//
// One byte is taken per cycle while the output is not stalled; each byte gives one result,
// held first by the input register and then by the result register around the parser logic.
// A stall on the output holds both registers; input is still taken while a slot is free.
// Reset is synchronous, active low, and the unit is ready for bytes in the cycle after it.
// The configuration register is always ready and takes a write whenever i_cfg_valid is high.
`default_nettype none

module binary_gnss_frame_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Byte input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_data_byte,
    // Result output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_payload_valid,
    output logic [7:0]       o_payload_byte,
    output logic [15:0]      o_payload_index,
    output logic [7:0]       o_msg_class,
    output logic [7:0]       o_msg_ident,
    output logic             o_frame_end,
    output logic             o_frame_known,
    output logic [2:0]       o_error_code,
    output logic [1:0]       o_ack_state,
    // Configuration write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_payload_limit
);
    import bgfp_pkg::*;

    logic        r_in_valid;
    logic        r_in_req;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_limit;
    logic        w_advance;
    t_result     w_result;

    // The input stage moves on when the result register is empty or being drained.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_req  <= i_req_type;
            r_in_byte <= i_data_byte;
        end
    end

    // Payload limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_AT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_payload_limit;
        end
    end

    bgfp_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_advance),
        .i_req_type      (r_in_req),
        .i_data_byte     (r_in_byte),
        .i_payload_limit (r_limit),
        .o_result        (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_index = r_out.payload_index;
    assign o_msg_class     = r_out.msg_class;
    assign o_msg_ident     = r_out.msg_ident;
    assign o_frame_end     = r_out.frame_end;
    assign o_frame_known   = r_out.frame_known;
    assign o_error_code    = r_out.error_code;
    assign o_ack_state     = r_out.ack_state;

endmodule

`default_nettype wire
